// File: src/heater_target_residency_monitor_assert.svh
// -----------------------------------------------------------------------------
// Assertion macros for the heater target residency monitor
// Shared property forms used by the checker.
// -----------------------------------------------------------------------------
`ifndef HEATER_TARGET_RESIDENCY_MONITOR_ASSERT_SVH
`define HEATER_TARGET_RESIDENCY_MONITOR_ASSERT_SVH

// Same-cycle implication, off while reset is asserted
`define HTRM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("htrm: assertion failed");

// Next-cycle implication, off while reset is asserted
`define HTRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("htrm: assertion failed");

// Next-cycle implication that also checks during reset
`define HTRM_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) (ante) |=> (cons)) \
    else $error("htrm: assertion failed");

`endif

// File: src/htrm_pkg.sv
// -----------------------------------------------------------------------------
// htrm_pkg
// Types and constants shared by the heater target residency monitor.
// -----------------------------------------------------------------------------
package htrm_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned ResMsW   = 18;  // 255 s * 1000 fits in 18 bits
  localparam int unsigned MsPerS   = 1000;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 16;

  // Register reset values
  localparam logic [8:0] RstMaxTemp  = 9'd290;
  localparam logic [7:0] RstMinTemp  = 8'd10;
  localparam logic [5:0] RstMargin   = 6'd15;
  localparam logic [4:0] RstWindow   = 5'd1;
  localparam logic [4:0] RstHyst     = 5'd3;
  localparam int unsigned RstResidencyS = 10;

  typedef enum logic {
    OP_SET  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_TEMP  = 3'd0,
    CFG_MIN_TEMP  = 3'd1,
    CFG_MARGIN    = 3'd2,
    CFG_WINDOW    = 3'd3,
    CFG_HYST      = 3'd4,
    CFG_RESIDENCY = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [8:0]        max_temp;
    logic [7:0]        min_temp;
    logic [5:0]        margin;
    logic [4:0]        window;
    logic [4:0]        hyst;
    logic [ResMsW-1:0] residency_ms;
  } cfg_t;

  typedef struct packed {
    op_e                operation;
    logic [8:0]         requested_target;
    logic signed [13:0] measured_temp;
    logic [31:0]        now_ms;
  } item_t;

  typedef struct packed {
    logic signed [9:0] active_target;
    logic              target_changed;
    logic              over_max_error;
    logic              under_min_error;
    logic              target_reached;
  } result_t;

endpackage

// File: src/htrm_cfg.sv
// -----------------------------------------------------------------------------
// htrm_cfg
// Configuration registers; residency time is kept in milliseconds.
// -----------------------------------------------------------------------------
module htrm_cfg import htrm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;
  logic [ResMsW-1:0] res_ms_d;

  // Scale seconds to milliseconds once, at write time
  assign res_ms_d = ResMsW'(cfg_data_i[7:0]) * ResMsW'(MsPerS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_temp     <= RstMaxTemp;
      cfg_q.min_temp     <= RstMinTemp;
      cfg_q.margin       <= RstMargin;
      cfg_q.window       <= RstWindow;
      cfg_q.hyst         <= RstHyst;
      cfg_q.residency_ms <= ResMsW'(RstResidencyS * MsPerS);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_TEMP:  cfg_q.max_temp     <= cfg_data_i[8:0];
        CFG_MIN_TEMP:  cfg_q.min_temp     <= cfg_data_i[7:0];
        CFG_MARGIN:    cfg_q.margin       <= cfg_data_i[5:0];
        CFG_WINDOW:    cfg_q.window       <= cfg_data_i[4:0];
        CFG_HYST:      cfg_q.hyst         <= cfg_data_i[4:0];
        CFG_RESIDENCY: cfg_q.residency_ms <= res_ms_d;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/htrm_core.sv
// -----------------------------------------------------------------------------
// htrm_core
// Target and residency state plus the per-item update logic.
// -----------------------------------------------------------------------------
module htrm_core import htrm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    fire_i,
  input  item_t   item_i,
  output result_t res_o
);

  logic signed [9:0] target_q, target_d;
  logic              tv_q, tv_d;
  logic [31:0]       start_q, start_d;
  logic              reached_q, reached_d;

  // Set path
  logic signed [10:0] limit, req_s, clamped;
  logic               set_changed;

  // Tick path
  logic signed [15:0] tgt16, meas16, diff, adiff;
  logic signed [15:0] max16, min16, win16, hyst16;
  logic               over, under, tgt_pos, begin_timing, end_timing;
  logic               tv_tick;
  logic [31:0]        start_tick, remain;
  logic               reached_tick;

  assign limit   = $signed({2'b00, cfg_i.max_temp}) - $signed({5'b00000, cfg_i.margin});
  assign req_s   = $signed({2'b00, item_i.requested_target});
  assign clamped = (req_s < limit) ? req_s : limit;
  assign set_changed = (clamped[9:0] != target_q);

  assign tgt16  = {{2{target_q[9]}}, target_q, 4'b0000};
  assign meas16 = {{2{item_i.measured_temp[13]}}, item_i.measured_temp};
  assign diff   = tgt16 - meas16;
  assign adiff  = diff[15] ? -diff : diff;
  assign max16  = {3'b000, cfg_i.max_temp, 4'b0000};
  assign min16  = {4'b0000, cfg_i.min_temp, 4'b0000};
  assign win16  = {7'b0000000, cfg_i.window, 4'b0000};
  assign hyst16 = {7'b0000000, cfg_i.hyst, 4'b0000};

  assign tgt_pos = !target_q[9] && (target_q != '0);
  assign over    = meas16 > max16;
  assign under   = tgt_pos && (meas16 < min16);

  // Enter on the window, leave on the hysteresis
  assign begin_timing = !tv_q && (adiff < win16);
  assign end_timing   = !begin_timing && (adiff > hyst16);
  assign tv_tick      = begin_timing ? 1'b1 : (end_timing ? 1'b0 : tv_q);
  assign start_tick   = begin_timing ? item_i.now_ms : (end_timing ? '0 : start_q);

  // Wrap-safe deadline test: reached once now - (start + residency) is non-negative
  assign remain       = item_i.now_ms - start_tick - {14'b0, cfg_i.residency_ms};
  assign reached_tick = !tgt_pos || (tv_tick && !remain[31]);

  always_comb begin
    target_d  = target_q;
    tv_d      = tv_q;
    start_d   = start_q;
    reached_d = reached_q;
    res_o     = '0;
    case (item_i.operation)
      OP_SET: begin
        if (set_changed) begin
          target_d = clamped[9:0];
          tv_d     = 1'b0;
          start_d  = '0;
        end
        res_o.active_target  = target_d;
        res_o.target_changed = set_changed;
        res_o.target_reached = reached_q;
      end
      OP_TICK: begin
        tv_d      = tv_tick;
        start_d   = start_tick;
        reached_d = reached_tick;
        res_o.active_target   = target_q;
        res_o.over_max_error  = over;
        res_o.under_min_error = under;
        res_o.target_reached  = reached_tick;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= '0;
      tv_q      <= 1'b0;
      start_q   <= '0;
      reached_q <= 1'b0;
    end else if (fire_i) begin
      target_q  <= target_d;
      tv_q      <= tv_d;
      start_q   <= start_d;
      reached_q <= reached_d;
    end
  end

endmodule

// File: src/heater_target_residency_monitor.sv
// -----------------------------------------------------------------------------
// heater_target_residency_monitor
// Clamps heater targets and tracks temperature residency near the target.
//
// Channel   Dir  Contents
// s_axis    in   tuser[0] operation; tdata requested_target, measured_temp, now_ms
// m_axis    out  tdata active_target, target_changed, errors, target_reached
// cfg       in   cfg_we_i / cfg_idx_i / cfg_data_i register write, no read-back
//
// One item per cycle while m_axis_tready stays high; each result shows on
// m_axis after its item passes the input register, then the result register.
// The state update and all compares sit between those two registers.
// A stalled result register holds; the input register still takes one item.
// Reset is asynchronous, active low, and clears state, configuration and the
// valid flags; no clearing pass follows.
// -----------------------------------------------------------------------------
module heater_target_residency_monitor import htrm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [8:0] requested_target, [22:9] measured_temp, [54:23] now_ms, [55] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] operation
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [9:0] active_target, [10] target_changed, [11] over_max_error,
  // [12] under_min_error, [13] target_reached, [15:14] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg;
  item_t   in_q;
  logic    in_valid_q;
  result_t res, out_q;
  logic    out_valid_q;
  logic    advance, fire, s_fire;

  htrm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  htrm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (fire),
    .item_i (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_fire) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_q.operation        <= op_e'(s_axis_tuser);
      in_q.requested_target <= s_axis_tdata[8:0];
      in_q.measured_temp    <= s_axis_tdata[22:9];
      in_q.now_ms           <= s_axis_tdata[54:23];
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.target_reached, out_q.under_min_error,
                          out_q.over_max_error, out_q.target_changed,
                          out_q.active_target};

endmodule

// File: src/htrm_checker.sv
// -----------------------------------------------------------------------------
// htrm_checker
// Port-level checks on the monitor, bound to the top level.
// -----------------------------------------------------------------------------
`include "heater_target_residency_monitor_assert.svh"

module htrm_checker import htrm_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // A stalled result keeps its valid and its data
  `HTRM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata))

  // With the result register empty the input side never stalls
  `HTRM_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

  // No result shows up right after reset
  `HTRM_ASSERT_RST(a_no_out_after_reset, !rst_ni, !m_axis_tvalid)

  // A new result needs an item offered earlier on the input side, or an earlier result
  `HTRM_ASSERT_NOW(a_out_needs_input, $rose(m_axis_tvalid),
                   $past(s_axis_tvalid, 2) || $past(s_axis_tvalid, 1) ||
                   $past(m_axis_tvalid, 2))

endmodule

bind heater_target_residency_monitor htrm_checker u_htrm_checker (.*);
